@@ src/broadcast_ring_fifo_assert.svh @@
// ----------------------------------------------------------------------------
// Broadcast ring FIFO assertion macros
// Shared property forms; each expects clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_RING_FIFO_ASSERT_SVH
`define BROADCAST_RING_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define BRF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define BRF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/brf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring FIFO package
// Shared codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int APB_DATA_W   = 32;
    localparam int ADDR_W       = 3;
    localparam int ACTIVE_RESET = 5;

    // Request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_INACTIVE = 2'd3;

    // Register index (word address bits of paddr)
    localparam logic REG_ACTIVE_READERS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RCHK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic write_go;
        logic read_go;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic req_read;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

@@ src/brf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring FIFO channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brf_req_if #(
    parameter int READER_W = 3
);
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [READER_W-1:0]               reader;
    logic signed [brf_pkg::DATA_W-1:0] write_data;

    modport source (output valid, output opcode, output reader, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input reader, input write_data,
                    output ready);
endinterface

interface brf_rsp_if #(
    parameter int LEVEL_W = 5
);
    logic                              valid;
    logic                              ready;
    logic [brf_pkg::STATUS_W-1:0]      status;
    logic signed [brf_pkg::DATA_W-1:0] read_data;
    logic [LEVEL_W-1:0]                level;

    modport source (output valid, output status, output read_data, output level,
                    input ready);
    modport sink   (input valid, input status, input read_data, input level,
                    output ready);
endinterface

@@ src/brf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring FIFO controller
// Sequences one request at a time: accept, scan then write or check, result.
// ----------------------------------------------------------------------------
module brf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  brf_pkg::dp_stat_t stat,
    output brf_pkg::dp_cmd_t  cmd
);

    brf_pkg::state_t state_reg;
    brf_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            brf_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.req_read ? brf_pkg::ST_RCHK : brf_pkg::ST_SCAN;
                end
            end
            brf_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = brf_pkg::ST_WRITE;
                end
            end
            brf_pkg::ST_WRITE:
            begin
                cmd.write_go = 1'b1;
                state_next   = brf_pkg::ST_RESULT;
            end
            brf_pkg::ST_RCHK:
            begin
                cmd.read_go = 1'b1;
                state_next  = brf_pkg::ST_RESULT;
            end
            brf_pkg::ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = brf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/brf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring FIFO datapath
// Word store, write pointer, per-reader pointers and counts, result register.
// ----------------------------------------------------------------------------
`include "broadcast_ring_fifo_assert.svh"

module brf_dp #(
    parameter int DEPTH       = 16,
    parameter int MAX_READERS = 8,
    parameter int READER_W    = 3,
    parameter int LEVEL_W     = 5,
    parameter int CFG_W       = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  brf_pkg::dp_cmd_t                  cmd,
    output brf_pkg::dp_stat_t                 stat,
    input  logic [CFG_W-1:0]                  active_readers,
    input  logic                              req_opcode,
    input  logic [READER_W-1:0]               req_reader,
    input  logic signed [brf_pkg::DATA_W-1:0] req_write_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [brf_pkg::STATUS_W-1:0]      rsp_status,
    output logic signed [brf_pkg::DATA_W-1:0] rsp_read_data,
    output logic [LEVEL_W-1:0]                rsp_level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [brf_pkg::DATA_W-1:0] storage [DEPTH];

    logic [PTR_W-1:0]             wptr_reg;
    logic [PTR_W-1:0]             rptr_reg [MAX_READERS];
    logic [LEVEL_W-1:0]           occ_reg  [MAX_READERS];

    logic                         op_reg;
    logic [READER_W-1:0]          reader_reg;
    logic [brf_pkg::DATA_W-1:0]   wdata_reg;
    logic [READER_W-1:0]          scan_idx_reg;
    logic [LEVEL_W-1:0]           max_reg;
    logic [brf_pkg::DATA_W-1:0]   mem_rdata_reg;
    logic [brf_pkg::STATUS_W-1:0] res_status_reg;
    logic [LEVEL_W-1:0]           res_level_reg;

    logic                         rsp_valid_reg;
    logic [brf_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [brf_pkg::DATA_W-1:0]   rsp_data_reg;
    logic [LEVEL_W-1:0]           rsp_level_reg;

    logic [CFG_W-1:0]   n_cnt;
    logic               full;
    logic               inactive;
    logic [LEVEL_W-1:0] occ_sel;
    logic [LEVEL_W-1:0] occ_scan;
    logic [PTR_W-1:0]   rptr_sel;
    logic [PTR_W-1:0]   rptr_inc;
    logic [PTR_W-1:0]   wptr_inc;

    // Clamp the reader count to 1 .. MAX_READERS
    always_comb
    begin
        if (active_readers == '0)
        begin
            n_cnt = CFG_W'(1);
        end
        else if (active_readers > CFG_W'(MAX_READERS))
        begin
            n_cnt = CFG_W'(MAX_READERS);
        end
        else
        begin
            n_cnt = active_readers;
        end
    end

    // Decode the selected reader and the scan position
    assign occ_scan = occ_reg[scan_idx_reg];
    assign occ_sel  = occ_reg[reader_reg];
    assign rptr_sel = rptr_reg[reader_reg];
    assign inactive = CFG_W'(reader_reg) >= n_cnt;
    assign full     = max_reg >= LEVEL_W'(DEPTH);
    assign rptr_inc = (rptr_sel == PTR_W'(DEPTH - 1)) ? '0 : rptr_sel + 1'b1;
    assign wptr_inc = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;

    assign stat.req_read  = req_opcode == brf_pkg::OP_READ;
    assign stat.scan_last = CFG_W'(scan_idx_reg) == n_cnt - 1'b1;
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    // Latch the request and run the highest-count scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= req_opcode;
            reader_reg   <= req_reader;
            wdata_reg    <= req_write_data;
            scan_idx_reg <= '0;
            max_reg      <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (occ_scan > max_reg)
            begin
                max_reg <= occ_scan;
            end
        end
    end

    // Word store: write on accepted writes, registered read on accepted reads
    always_ff @(posedge clk)
    begin
        if (cmd.write_go && !full)
        begin
            storage[wptr_reg] <= wdata_reg;
        end
        if (cmd.read_go && !inactive && occ_sel != '0)
        begin
            mem_rdata_reg <= storage[rptr_sel];
        end
    end

    // Update pointers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                rptr_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
        end
        else if (cmd.write_go && !full)
        begin
            wptr_reg <= wptr_inc;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                if (CFG_W'(i) < n_cnt)
                begin
                    occ_reg[i] <= occ_reg[i] + 1'b1;
                end
            end
        end
        else if (cmd.read_go && !inactive && occ_sel != '0)
        begin
            rptr_reg[reader_reg] <= rptr_inc;
            occ_reg[reader_reg]  <= occ_sel - 1'b1;
        end
    end

    // Form the status and level of the request
    always_ff @(posedge clk)
    begin
        if (cmd.write_go)
        begin
            res_status_reg <= full ? brf_pkg::STAT_FULL : brf_pkg::STAT_OK;
            res_level_reg  <= full ? max_reg : max_reg + 1'b1;
        end
        else if (cmd.read_go)
        begin
            if (inactive)
            begin
                res_status_reg <= brf_pkg::STAT_INACTIVE;
                res_level_reg  <= '0;
            end
            else if (occ_sel == '0)
            begin
                res_status_reg <= brf_pkg::STAT_EMPTY;
                res_level_reg  <= '0;
            end
            else
            begin
                res_status_reg <= brf_pkg::STAT_OK;
                res_level_reg  <= occ_sel - 1'b1;
            end
        end
    end

    // Output register: hold until the response is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_level_reg  <= res_level_reg;
            if (op_reg == brf_pkg::OP_READ && res_status_reg == brf_pkg::STAT_OK)
            begin
                rsp_data_reg <= mem_rdata_reg;
            end
            else
            begin
                rsp_data_reg <= '0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign rsp_status    = rsp_status_reg;
    assign rsp_read_data = rsp_data_reg;
    assign rsp_level     = rsp_level_reg;

    // Checks
    `BRF_ASSERT(a_level_range, rsp_valid_reg, rsp_level_reg <= LEVEL_W'(DEPTH), "level above depth")
    `BRF_ASSERT(a_reject_zero, rsp_valid_reg && rsp_status_reg != brf_pkg::STAT_OK, rsp_data_reg == '0, "rejected request carries data")
    `BRF_ASSERT_NXT(a_full_hold, cmd.write_go && full, $stable(wptr_reg), "full write moved write pointer")

endmodule

@@ src/broadcast_ring_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring FIFO
// One writer, several readers; each active reader sees every stored word.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries
//  req      in   opcode, reader, write_data
//  rsp      out  status, read_data, level
//  APB      in   active_readers at word 0
//
//  A read passes from acceptance through the check state and the result state;
//  a write runs a serial scan for the highest reader count over the clamped
//  active readers (one reader per cycle), then the write and result states.
//  Reset clears pointers and counts and sets active_readers to 5; the word
//  store is not cleared.
//  A stalled response holds in the output register; one further request is
//  taken meanwhile and waits for the register to free before it completes.
// ----------------------------------------------------------------------------
module broadcast_ring_fifo #(
    parameter int DEPTH       = 16,
    parameter int MAX_READERS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    brf_req_if.sink                            req,
    brf_rsp_if.source                          rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [brf_pkg::ADDR_W-1:0]         paddr,
    input  logic [brf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [brf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int READER_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int LEVEL_W  = $clog2(DEPTH + 1);
    localparam int CFG_W    = ($clog2(MAX_READERS + 1) < 4) ? 4 : $clog2(MAX_READERS + 1);

    logic [CFG_W-1:0]  active_readers_reg;
    logic              reg_idx;
    brf_pkg::dp_cmd_t  cmd;
    brf_pkg::dp_stat_t stat;

    // Register decode
    assign reg_idx = paddr[brf_pkg::ADDR_W-1];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == brf_pkg::REG_ACTIVE_READERS)
                   ? brf_pkg::APB_DATA_W'(active_readers_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_readers_reg <= CFG_W'(brf_pkg::ACTIVE_RESET);
        end
        else if (psel && penable && pwrite && reg_idx == brf_pkg::REG_ACTIVE_READERS)
        begin
            active_readers_reg <= pwdata[CFG_W-1:0];
        end
    end

    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    brf_dp #(
        .DEPTH       (DEPTH),
        .MAX_READERS (MAX_READERS),
        .READER_W    (READER_W),
        .LEVEL_W     (LEVEL_W),
        .CFG_W       (CFG_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .active_readers (active_readers_reg),
        .req_opcode     (req.opcode),
        .req_reader     (req.reader),
        .req_write_data (req.write_data),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_read_data  (rsp.read_data),
        .rsp_level      (rsp.level)
    );

endmodule
